// ===== rtl/core/snr_pkg.sv =====
// ----------------------------------------------------------------------------
// snr_pkg
// Shared types and constants of the stochastic row normalizer.
// ----------------------------------------------------------------------------
package snr_pkg;

  localparam int unsigned MaxDegrees = 64;

  localparam int unsigned EntryW = 24;
  localparam int unsigned SumW   = 31;
  localparam int unsigned TotW   = 30;
  localparam int unsigned TolW   = 16;
  localparam int unsigned RowLenW = 7;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned DivW   = 30;
  localparam int unsigned DvdW   = 40;
  localparam int unsigned DivSteps = 40;
  localparam int unsigned StepW  = 6;

  localparam int OneQ16  = 65536;
  localparam int ProbMax = 8388607;
  localparam int AccMax  = 1073741823;
  localparam int AccMin  = -1073741824;
  localparam int TotMax  = 536870911;
  localparam int TotMin  = -536870912;

  localparam logic [RowLenW-1:0] RowLengthRst = 7'd64;
  localparam logic [TolW-1:0]    ToleranceRst = 16'd66;

  localparam logic CfgRowLength = 1'b0;
  localparam logic CfgTolerance = 1'b1;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StLoad,
    StDiv,
    StEmit
  } snr_state_e;

endpackage

// ===== rtl/core/snr_ram.sv =====
// ----------------------------------------------------------------------------
// snr_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module snr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/core/stochastic_row_normalizer.sv =====
// ----------------------------------------------------------------------------
// stochastic_row_normalizer
// Stores one matrix row of signed Q8.16 weights, sums it, then emits each
// weight divided by the row sum (uniform value if the sum is not positive).
//
//   channel   handshake                  payload
//   --------  -------------------------  -----------------------------------
//   entry     start_i / busy_o           entry_value_i
//   result    result_valid_o (strobe)    prob_value_o, row_total_o,
//                                        row_ok_o, last_of_row_o
//   config    cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A closing entry raises busy_o until all n results of the row are out, n the
// row length: per result a RAM read state, a divider load state, 40 restoring
// divide steps and an output state. The row store holds no reset; counters and
// control registers clear on rst_ni, the divider registers do not.
// The receiver cannot stall; each result strobe lasts one cycle.
// ----------------------------------------------------------------------------
module stochastic_row_normalizer #(
  parameter int unsigned MAX_DEGREES = snr_pkg::MaxDegrees
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [snr_pkg::EntryW-1:0]   entry_value_i,
  output logic                                result_valid_o,
  output logic signed [snr_pkg::EntryW-1:0]   prob_value_o,
  output logic signed [snr_pkg::TotW-1:0]     row_total_o,
  output logic                                row_ok_o,
  output logic                                last_of_row_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [snr_pkg::CfgDataW-1:0]        cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_DEGREES + 1);
  localparam int unsigned AW = (MAX_DEGREES > 1) ? $clog2(MAX_DEGREES) : 1;
  localparam int unsigned EW = (CW > snr_pkg::RowLenW) ? CW : snr_pkg::RowLenW;
  localparam logic [EW-1:0] MaxEw = EW'(MAX_DEGREES);

  snr_pkg::snr_state_e state_q, state_d;

  logic [snr_pkg::RowLenW-1:0]     row_len_q;
  logic [snr_pkg::TolW-1:0]        tolerance_q;
  logic [CW-1:0]                   count_q;
  logic signed [snr_pkg::SumW-1:0] sum_q;
  logic signed [snr_pkg::SumW-1:0] total_q;
  logic [CW-1:0]                   n_q;
  logic [AW-1:0]                   k_q;
  logic [snr_pkg::DivW-1:0]        rem_q;
  logic [snr_pkg::DvdW-1:0]        dq_q;
  logic [snr_pkg::DivW-1:0]        div_q;
  logic                            neg_q;
  logic [snr_pkg::StepW-1:0]       step_q;

  logic                            accept;
  logic                            closing;
  logic [EW-1:0]                   rl_ext;
  logic [EW-1:0]                   eff_len;
  logic [EW-1:0]                   cnt_inc;
  logic signed [31:0]              sum_wide;
  logic signed [snr_pkg::SumW-1:0] sum_d;
  logic                            last;
  logic                            div_done;
  logic [snr_pkg::EntryW-1:0]      rd_data;
  logic [snr_pkg::EntryW-1:0]      mag;
  logic                            pos_total;
  logic [snr_pkg::DivW:0]          trial;
  logic [snr_pkg::DivW:0]          diff;
  logic                            ge;
  logic signed [31:0]              sum_dev;
  logic [31:0]                     sum_dev_abs;
  logic                            wr_en;

  snr_ram #(
    .WIDTH (snr_pkg::EntryW),
    .DEPTH (MAX_DEGREES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (entry_value_i),
    .raddr_i (k_q),
    .rdata_o (rd_data)
  );

  assign cfg_ready_o = 1'b1;
  assign accept      = start_i && !busy_o;
  assign wr_en       = accept && (count_q < CW'(MAX_DEGREES));

  assign rl_ext  = EW'(row_len_q);
  assign eff_len = (rl_ext == '0) ? EW'(1) : ((rl_ext > MaxEw) ? MaxEw : rl_ext);
  assign cnt_inc = EW'(count_q) + EW'(1);
  assign closing = accept && (cnt_inc >= eff_len);

  always_comb begin
    sum_wide = 32'(sum_q) + 32'(entry_value_i);
    if (sum_wide > snr_pkg::AccMax) begin
      sum_d = snr_pkg::SumW'(snr_pkg::AccMax);
    end else if (sum_wide < snr_pkg::AccMin) begin
      sum_d = snr_pkg::SumW'(snr_pkg::AccMin);
    end else begin
      sum_d = sum_wide[snr_pkg::SumW-1:0];
    end
  end

  assign last      = (CW'(k_q) == (n_q - CW'(1)));
  assign div_done  = (step_q == snr_pkg::StepW'(snr_pkg::DivSteps - 1));
  assign pos_total = (total_q > 0);
  assign mag       = rd_data[snr_pkg::EntryW-1] ? (~rd_data + 24'd1) : rd_data;

  assign trial = {rem_q, dq_q[snr_pkg::DvdW-1]};
  assign diff  = trial - {1'b0, div_q};
  assign ge    = (trial >= {1'b0, div_q});

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      snr_pkg::StIdle: if (closing) state_d = snr_pkg::StRead;
      snr_pkg::StRead: state_d = snr_pkg::StLoad;
      snr_pkg::StLoad: state_d = snr_pkg::StDiv;
      snr_pkg::StDiv:  if (div_done) state_d = snr_pkg::StEmit;
      snr_pkg::StEmit: state_d = last ? snr_pkg::StIdle : snr_pkg::StRead;
      default:         state_d = snr_pkg::StIdle;
    endcase
  end

  // handshake outputs
  always_comb begin
    busy_o         = 1'b1;
    result_valid_o = 1'b0;
    case (state_q)
      snr_pkg::StIdle: busy_o = 1'b0;
      snr_pkg::StEmit: result_valid_o = 1'b1;
      default: begin
        busy_o         = 1'b1;
        result_valid_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= snr_pkg::StIdle;
      row_len_q   <= snr_pkg::RowLengthRst;
      tolerance_q <= snr_pkg::ToleranceRst;
      count_q     <= '0;
      sum_q       <= '0;
      total_q     <= '0;
      n_q         <= '0;
      k_q         <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          snr_pkg::CfgRowLength: row_len_q   <= cfg_data_i[snr_pkg::RowLenW-1:0];
          snr_pkg::CfgTolerance: tolerance_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (accept) begin
        if (closing) begin
          count_q <= '0;
          sum_q   <= '0;
          total_q <= sum_d;
          n_q     <= cnt_inc[CW-1:0];
          k_q     <= '0;
        end else begin
          count_q <= count_q + CW'(1);
          sum_q   <= sum_d;
        end
      end
      if (state_q == snr_pkg::StEmit && !last) begin
        k_q <= k_q + AW'(1);
      end
    end
  end

  // divider datapath
  always_ff @(posedge clk_i) begin
    if (state_q == snr_pkg::StLoad) begin
      rem_q  <= '0;
      step_q <= '0;
      dq_q   <= pos_total ? {mag, 16'd0} : snr_pkg::DvdW'(snr_pkg::OneQ16);
      div_q  <= pos_total ? total_q[snr_pkg::DivW-1:0] : snr_pkg::DivW'(n_q);
      neg_q  <= pos_total && rd_data[snr_pkg::EntryW-1];
    end else if (state_q == snr_pkg::StDiv) begin
      rem_q  <= ge ? diff[snr_pkg::DivW-1:0] : trial[snr_pkg::DivW-1:0];
      dq_q   <= {dq_q[snr_pkg::DvdW-2:0], ge};
      step_q <= step_q + snr_pkg::StepW'(1);
    end
  end

  // result payload
  always_comb begin
    if (!neg_q) begin
      if (dq_q > snr_pkg::DvdW'(snr_pkg::ProbMax)) begin
        prob_value_o = 24'sh7FFFFF;
      end else begin
        prob_value_o = $signed(dq_q[snr_pkg::EntryW-1:0]);
      end
    end else begin
      if (dq_q > snr_pkg::DvdW'(snr_pkg::ProbMax)) begin
        prob_value_o = 24'sh800000;
      end else begin
        prob_value_o = $signed(~dq_q[snr_pkg::EntryW-1:0] + 24'd1);
      end
    end
  end

  always_comb begin
    if (total_q > snr_pkg::TotMax) begin
      row_total_o = snr_pkg::TotW'(snr_pkg::TotMax);
    end else if (total_q < snr_pkg::TotMin) begin
      row_total_o = snr_pkg::TotW'(snr_pkg::TotMin);
    end else begin
      row_total_o = total_q[snr_pkg::TotW-1:0];
    end
  end

  assign sum_dev       = 32'(total_q) - 32'(snr_pkg::OneQ16);
  assign sum_dev_abs   = sum_dev[31] ? $unsigned(-sum_dev) : $unsigned(sum_dev);
  assign row_ok_o      = (sum_dev_abs <= 32'(tolerance_q));
  assign last_of_row_o = last;

endmodule

// ===== rtl/core/snr_checker.sv =====
// ----------------------------------------------------------------------------
// snr_checker
// Port-level checks of the stochastic row normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module snr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic result_valid_o,
  input logic last_of_row_o
);

  a_result_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o)
    else $error("result strobe while not busy");

  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("back-to-back result strobes");

  a_row_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !last_of_row_o) |=> busy_o)
    else $error("row dropped before its last result");

  a_row_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_of_row_o) |=> !busy_o)
    else $error("busy held after last result of row");

  a_start_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !result_valid_o)
    else $error("result right after a transfer");

endmodule

bind stochastic_row_normalizer snr_checker u_snr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .last_of_row_o  (last_of_row_o)
);
